### sv/bbea_pkg.sv
package bbea_pkg;

    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int FW_W      = 11;
    localparam int FH_W      = 13;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int SUM_W     = 12;
    localparam int CNT_W     = 4;
    localparam int NUM_W     = 13;
    localparam int RECIP_W   = 20;
    localparam int PROD_W    = NUM_W + RECIP_W;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(1024);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(1024);

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    typedef struct packed {
        logic              func;
        logic [CH_W-1:0]   in_red;
        logic [CH_W-1:0]   in_green;
        logic [CH_W-1:0]   in_blue;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0]   out_red;
        logic [CH_W-1:0]   out_green;
        logic [CH_W-1:0]   out_blue;
        logic              out_last;
    } t_pix_out;

    // ceil(2^RECIP_W / (2*cnt)), exact for numerators below 2^NUM_W
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = RECIP_W'(524288);
            4'd2:    m = RECIP_W'(262144);
            4'd3:    m = RECIP_W'(174763);
            4'd4:    m = RECIP_W'(131072);
            4'd6:    m = RECIP_W'(87382);
            4'd9:    m = RECIP_W'(58255);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

### sv/box_blur_3x3_edge_adaptive.sv
// channel   dir  signals                                  beat when
// pixel in  in   i_in_valid / o_in_ready, i_in_data       valid & ready
// pixel out out  o_out_valid / i_out_ready, o_out_data    valid & ready
// config    in   psel penable pwrite paddr pwdata prdata  psel & penable & pwrite
//
// a beat that releases no output keeps the block idle; a beat that releases
// one makes 9 neighbor reads through the single read port of the row store,
// then accumulate, reciprocal multiply and output load (waiting in output load
// while the output register is still full). the output register lets the next
// beat enter while a result waits. reset sets width and height to 1024 and all
// position counters to zero; the row store is not cleared.
module box_blur_3x3_edge_adaptive #(
    parameter int MAX_WIDTH  = bbea_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bbea_pkg::DEF_MAX_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bbea_pkg::t_pix_in             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bbea_pkg::t_pix_out            o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bbea_pkg::PADDR_W-1:0]  paddr,
    input  logic [bbea_pkg::PDATA_W-1:0]  pwdata,
    output logic [bbea_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CHW   = bbea_pkg::CH_W;
    localparam int PW    = bbea_pkg::PIX_W;
    localparam int SW    = bbea_pkg::SUM_W;
    localparam int NW    = bbea_pkg::CNT_W;
    localparam int QSH   = bbea_pkg::RECIP_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_ACC  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [bbea_pkg::FW_W-1:0] r_fw;
    logic [bbea_pkg::FH_W-1:0] r_fh;
    logic [WW-1:0] w_eff;
    logic [RW-1:0] h_eff;

    logic [CW-1:0] r_in_col, n_in_col, r_out_col, n_out_col;
    logic [RW-1:0] r_in_row, n_in_row, r_out_row, n_out_row;
    logic [1:0]    r_in_slot, n_in_slot, r_out_slot, n_out_slot;

    // working copy of the beat in flight
    logic [2:0][CHW-1:0] r_pix;
    logic [CW-1:0]       r_pc, r_oc;
    logic [RW-1:0]       r_pr, r_or;
    logic [1:0]          r_pslot, r_oslot;
    logic                r_carried, r_last;
    logic [1:0]          r_dr, r_dc;

    logic                r_p_live, r_p_valid, r_p_fwd;
    logic [SW-1:0]       r_sum [3];
    logic [NW-1:0]       r_cnt;
    logic [CHW-1:0]      r_quo [3];

    logic [PW-1:0]       r_mem [DEPTH];
    logic [2:0][CHW-1:0] r_rdata;

    logic                r_ov;
    bbea_pkg::t_pix_out  r_out;

    logic cfg_wr, in_accept, in_done, is_pixel, acc_carried, acc_emit, eof;
    logic out_load;
    logic nb_row_ok, nb_col_ok, nb_fwd;
    logic [1:0]    nb_slot;
    logic [CW-1:0] nb_col;
    logic [AW-1:0] rd_addr, wr_addr, nb_base, pw_base;
    logic          rd_en, wr_en;
    logic [PW-1:0] wr_data;
    logic [RW:0]   in_row_inc, out_row_inc;
    logic [CW:0]   in_col_inc, out_col_inc;
    logic [bbea_pkg::RECIP_W-1:0] m_recip;
    logic [bbea_pkg::NUM_W-1:0]   num [3];
    logic [bbea_pkg::PROD_W-1:0]  prod [3];

    function automatic logic [AW-1:0] slot_base(input logic [1:0] s);
        logic [AW-1:0] b;
        case (s)
            2'd1:    b = AW'(MAX_WIDTH);
            2'd2:    b = AW'(2 * MAX_WIDTH);
            default: b = '0;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] slot_inc(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic logic [1:0] slot_dec(input logic [1:0] s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        case (paddr[2:2])
            bbea_pkg::REG_FRAME_HEIGHT: prdata = bbea_pkg::PDATA_W'(r_fh);
            default:                    prdata = bbea_pkg::PDATA_W'(r_fw);
        endcase
    end

    // zero reads as one, oversize saturates
    always_comb begin
        if (r_fw == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_fw) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_fw);
        end
        if (r_fh == '0) begin
            h_eff = RW'(1);
        end else if (32'(r_fh) > MAX_HEIGHT) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(r_fh);
        end
    end

    // beat decode and position counters
    always_comb begin
        in_done     = (r_in_row >= h_eff);
        is_pixel    = (i_in_data.func == bbea_pkg::FUNC_PIXEL);
        acc_carried = !in_done && is_pixel;
        if (in_done) begin
            acc_emit = (r_out_row < h_eff);
        end else begin
            acc_emit = is_pixel && ((32'(r_in_row) >= 2) ||
                       ((32'(r_in_row) == 1) && (r_in_col != '0)));
        end
        in_col_inc  = {1'b0, r_in_col} + (CW+1)'(1);
        out_col_inc = {1'b0, r_out_col} + (CW+1)'(1);
        in_row_inc  = {1'b0, r_in_row} + (RW+1)'(1);
        out_row_inc = {1'b0, r_out_row} + (RW+1)'(1);
        eof = (out_col_inc >= (CW+1)'(w_eff)) && (out_row_inc >= (RW+1)'(h_eff));

        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_in_slot  = r_in_slot;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_out_slot = r_out_slot;
        if (cfg_wr) begin
            n_in_col   = '0;
            n_in_row   = '0;
            n_in_slot  = '0;
            n_out_col  = '0;
            n_out_row  = '0;
            n_out_slot = '0;
        end else if (in_accept) begin
            if (acc_carried) begin
                if (in_col_inc >= (CW+1)'(w_eff)) begin
                    n_in_col  = '0;
                    n_in_row  = RW'(in_row_inc);
                    n_in_slot = slot_inc(r_in_slot);
                end else begin
                    n_in_col = CW'(in_col_inc);
                end
            end
            if (acc_emit) begin
                if (eof) begin
                    n_in_col   = '0;
                    n_in_row   = '0;
                    n_in_slot  = '0;
                    n_out_col  = '0;
                    n_out_row  = '0;
                    n_out_slot = '0;
                end else if (out_col_inc >= (CW+1)'(w_eff)) begin
                    n_out_col  = '0;
                    n_out_row  = RW'(out_row_inc);
                    n_out_slot = slot_inc(r_out_slot);
                end else begin
                    n_out_col = CW'(out_col_inc);
                end
            end
        end
    end

    // neighbor (r_dr, r_dc) of the output pixel, offsets stored plus one
    always_comb begin
        case (r_dr)
            2'd0: begin
                nb_row_ok = (r_or != '0);
                nb_slot   = slot_dec(r_oslot);
            end
            2'd2: begin
                nb_row_ok = (({1'b0, r_or} + (RW+1)'(1)) < (RW+1)'(h_eff));
                nb_slot   = slot_inc(r_oslot);
            end
            default: begin
                nb_row_ok = 1'b1;
                nb_slot   = r_oslot;
            end
        endcase
        case (r_dc)
            2'd0:    nb_col_ok = (r_oc != '0);
            2'd2:    nb_col_ok = (({1'b0, r_oc} + (CW+1)'(1)) < (CW+1)'(w_eff));
            default: nb_col_ok = 1'b1;
        endcase
        nb_col  = CW'(r_oc + CW'(r_dc) - CW'(1));
        nb_fwd  = r_carried &&
                  (({1'b0, r_or} + (RW+1)'(r_dr)) == ({1'b0, r_pr} + (RW+1)'(1))) &&
                  (({1'b0, r_oc} + (CW+1)'(r_dc)) == ({1'b0, r_pc} + (CW+1)'(1)));
        nb_base = slot_base(nb_slot);
        rd_addr = AW'(nb_base + AW'(nb_col));
        rd_en   = (r_state == ST_READ);
    end

    // pixel write: at accept for a beat with no output, after the reads otherwise
    always_comb begin
        if (r_state == ST_ACC) begin
            wr_en   = r_carried;
            pw_base = slot_base(r_pslot);
            wr_addr = AW'(pw_base + AW'(r_pc));
            wr_data = r_pix;
        end else begin
            wr_en   = in_accept && acc_carried && !acc_emit;
            pw_base = slot_base(r_in_slot);
            wr_addr = AW'(pw_base + AW'(r_in_col));
            wr_data = {i_in_data.in_red, i_in_data.in_green, i_in_data.in_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // mean = (2*sum + cnt) / (2*cnt) through a reciprocal
    always_comb begin
        m_recip = bbea_pkg::recip(r_cnt);
        for (int k = 0; k < 3; k++) begin
            num[k]  = bbea_pkg::NUM_W'({r_sum[k], 1'b0}) + bbea_pkg::NUM_W'(r_cnt);
            prod[k] = bbea_pkg::PROD_W'(num[k]) * bbea_pkg::PROD_W'(m_recip);
        end
    end

    assign out_load = (r_state == ST_OUT) && (!r_ov || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && acc_emit) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_dr == 2'd2 && r_dc == 2'd2) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fw       <= bbea_pkg::FRAME_WIDTH_RST;
            r_fh       <= bbea_pkg::FRAME_HEIGHT_RST;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_p_live   <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_in_slot  <= n_in_slot;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_out_slot <= n_out_slot;
            if (cfg_wr) begin
                if (paddr[2:2] == bbea_pkg::REG_FRAME_WIDTH) begin
                    r_fw <= pwdata[bbea_pkg::FW_W-1:0];
                end else begin
                    r_fh <= pwdata[bbea_pkg::FH_W-1:0];
                end
            end
            r_p_live <= (r_state == ST_READ);
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pix     <= {i_in_data.in_red, i_in_data.in_green, i_in_data.in_blue};
            r_pr      <= r_in_row;
            r_pc      <= r_in_col;
            r_pslot   <= r_in_slot;
            r_or      <= r_out_row;
            r_oc      <= r_out_col;
            r_oslot   <= r_out_slot;
            r_carried <= acc_carried;
            r_last    <= eof;
            r_dr      <= '0;
            r_dc      <= '0;
            r_cnt     <= '0;
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= '0;
            end
        end else begin
            if (r_state == ST_READ) begin
                if (r_dc == 2'd2) begin
                    r_dc <= '0;
                    r_dr <= r_dr + 2'd1;
                end else begin
                    r_dc <= r_dc + 2'd1;
                end
            end
            // accumulate the neighbor read in the previous cycle
            if (r_p_live && r_p_valid) begin
                r_cnt <= r_cnt + NW'(1);
                for (int k = 0; k < 3; k++) begin
                    r_sum[k] <= r_sum[k] + SW'(r_p_fwd ? r_pix[2-k] : r_rdata[2-k]);
                end
            end
        end
        r_p_valid <= nb_row_ok && nb_col_ok;
        r_p_fwd   <= nb_fwd;
        if (r_state == ST_MUL) begin
            for (int k = 0; k < 3; k++) begin
                r_quo[k] <= prod[k][QSH+CHW-1:QSH];
            end
        end
        if (out_load) begin
            r_out.out_red   <= r_quo[0];
            r_out.out_green <= r_quo[1];
            r_out.out_blue  <= r_quo[2];
            r_out.out_last  <= r_last;
        end
    end

endmodule
